/* sv/stb_pkg.sv */
// ---------------------------------------------------------------------------
// Script text to bytecode: shared package
// Parse modes, result types, command name table and argument counts.
// ---------------------------------------------------------------------------
`default_nettype none

package stb_pkg;

	localparam int ARG_DIGITS  = 4;
	localparam int NUM_OPS     = 91;
	localparam int MAX_RESULTS = 9;
	localparam int OP_IDX_W    = 7;
	localparam int CNT_W       = 4;

	localparam logic [7:0] STR_MARK  = 8'hFF;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [2:0] {
		M_IDLE = 3'd0,
		M_TOP  = 3'd1,
		M_TEXT = 3'd2,
		M_NAME = 3'd3,
		M_ARG  = 3'd4,
		M_ACOL = 3'd5
	} mode_t;

	typedef struct packed {
		logic [7:0] code;
		logic       err;
		logic       done;
	} res_t;

	typedef struct packed {
		res_t [MAX_RESULTS-1:0] r;
		logic [CNT_W-1:0]       cnt;
	} batch_t;

	typedef struct packed {
		logic                hit;
		logic [OP_IDX_W-1:0] idx;
	} look_t;

	localparam logic [23:0] OP_NAMES [NUM_OPS] = '{
		"END", "MSG", "MS2", "MS3", "EVE", "UNJ", "MPJ", "YNJ", "NCJ", "ECJ",
		"FLJ", "ITJ", "SKJ", "AMJ", "FRE", "FAI", "FAO", "WAI", "WAS", "KEY",
		"PRI", "NOD", "CAT", "SAT", "TUR", "CLO", "CLR", "FAC", "GIT", "NUM",
		"MM0", "HMC", "SMC", "UNI", "MYB", "MYD", "MOV", "TRA", "FOB", "FOM",
		"FON", "FLA", "QUA", "ANP", "CNP", "INP", "MNP", "SNP", "DNA", "DNP",
		"BOA", "BSL", "EQ+", "EQ-", "IT+", "IT-", "AM+", "AM-", "TAM", "AE+",
		"ML+", "LI+", "MLP", "MNA", "CMP", "SMP", "FL+", "FL-", "MP+", "SK+",
		"SK-", "SOU", "SSS", "CSS", "SPS", "CPS", "CMU", "FMU", "RMU", "SVP",
		"LDP", "STC", "CRE", "XX1", "SIL", "CIL", "ESC", "INI", "PS+", "SLP",
		"ZAM"
	};

	localparam logic [2:0] OP_ARGS [NUM_OPS] = '{
		3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
		3'd2, 3'd2, 3'd2, 3'd2, 3'd0, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0,
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd0,
		3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd4, 3'd2, 3'd1,
		3'd2, 3'd0, 3'd1, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd1, 3'd1,
		3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd1, 3'd3, 3'd0,
		3'd1, 3'd1, 3'd0, 3'd0, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1,
		3'd1, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd0, 3'd0,
		3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd0, 3'd0, 3'd0, 3'd2, 3'd0,
		3'd0
	};

	// Parallel compare against every table entry.
	function automatic look_t op_lookup(input logic [23:0] nm);
		look_t l;
		l = '0;
		for (int i = NUM_OPS - 1; i >= 0; i--) begin
			if (OP_NAMES[i] == nm) begin
				l.hit = 1'b1;
				l.idx = OP_IDX_W'(i);
			end
		end
		return l;
	endfunction

endpackage

`default_nettype wire

/* sv/script_text_to_bytecode.sv */
// ---------------------------------------------------------------------------
// Script text to bytecode compiler
// Top level: parser and result buffer.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) takes one text byte per request,
//   with new_event set on the first byte of each event. The output channel
//   (out_valid/out_ready) gives one bytecode byte per request; last_of_run
//   marks the final result of an input byte's batch, event_done the final
//   result of the event, and error an unknown command name.
//   A byte is parsed in the cycle it is accepted and its results appear
//   from the next cycle on, one per cycle while out_ready is high. A byte
//   giving at most one result is then taken every cycle; one giving more
//   holds the result buffer until all have left, as the output port moves
//   one result per cycle. Bytes giving no result (name characters, ignored
//   idle bytes) never stall. A new byte is taken in the same cycle as the
//   last result of the previous one leaves. If the receiver stalls, results
//   hold and in_ready stays low until the buffer's last result is taken.
//   Reset leaves the parser idle: bytes are dropped until new_event.
// ---------------------------------------------------------------------------
`default_nettype none

module script_text_to_bytecode (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] ch,
	input  wire logic       new_event,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      code_byte,
	output logic            error,
	output logic            event_done,
	output logic            last_of_run
);
	import stb_pkg::*;

	batch_t batch;
	logic   load;
	logic   free;

	assign in_ready = free;
	assign load     = in_valid && free;

	stb_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.ch        (ch),
		.new_event (new_event),
		.batch     (batch)
	);

	stb_outbuf u_outbuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.batch       (batch),
		.free        (free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.code_byte   (code_byte),
		.error       (error),
		.event_done  (event_done),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

/* sv/stb_parse.sv */
// ---------------------------------------------------------------------------
// Script text to bytecode: parser
// Holds the parse state and turns one text byte into a batch of results.
// ---------------------------------------------------------------------------
`default_nettype none

module stb_parse (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load,
	input  wire logic [7:0]     ch,
	input  wire logic           new_event,
	output stb_pkg::batch_t     batch
);
	import stb_pkg::*;

	mode_t       mode_q, m;
	logic [15:0] name_q, nm;
	logic [1:0]  ncnt_q, nc;
	logic [2:0]  args_q, al;
	logic [2:0]  dc_q, dc;
	logic [13:0] val_q, v;
	logic        pv_q, pv;
	logic [7:0]  pb_q, pb;
	res_t        res [MAX_RESULTS+1];
	logic [CNT_W-1:0] n;
	logic        used;
	logic        is_digit;
	logic [17:0] mul;
	look_t       lk;

	assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign lk = op_lookup({name_q, ch});

	always_comb begin
		m    = mode_q;
		nm   = name_q;
		nc   = ncnt_q;
		al   = args_q;
		dc   = dc_q;
		v    = val_q;
		pv   = pv_q;
		pb   = pb_q;
		n    = '0;
		used = 1'b0;
		mul  = '0;
		for (int i = 0; i <= MAX_RESULTS; i++) begin
			res[i] = '0;
		end

		if (new_event) begin
			m  = M_TOP;
			nm = '0;
			nc = '0;
			al = '0;
			dc = '0;
			v  = '0;
			pv = 1'b0;
		end else if (pv_q) begin
			res[n] = '{code: pb_q, err: 1'b0, done: 1'b0};
			n = n + 1'b1;
			pv = 1'b0;
		end

		if (m == M_ACOL) begin
			m = (al != 3'd0) ? M_ARG : M_TOP;
			used = (ch == CH_COLON);
		end

		if (!used && m == M_ARG) begin
			if (al == 3'd0) begin
				m = M_TOP;
			end else if (is_digit) begin
				mul = {v, 3'b000} + {3'b000, v, 1'b0} + {14'd0, ch[3:0]};
				v = mul[13:0];
				dc = dc + 3'd1;
				used = 1'b1;
				if (dc >= 3'(ARG_DIGITS)) begin
					res[n] = '{code: v[7:0], err: 1'b0, done: 1'b0};
					n = n + 1'b1;
					res[n] = '{code: {2'b00, v[13:8]}, err: 1'b0, done: 1'b0};
					n = n + 1'b1;
					al = al - 3'd1;
					v  = '0;
					dc = '0;
					m  = M_ACOL;
				end
			end else begin
				res[n] = '{code: v[7:0], err: 1'b0, done: 1'b0};
				n = n + 1'b1;
				res[n] = '{code: {2'b00, v[13:8]}, err: 1'b0, done: 1'b0};
				n = n + 1'b1;
				v  = '0;
				dc = '0;
				if (ch == CH_COLON) begin
					al = al - 3'd1;
					if (al == 3'd0) begin
						m = M_TOP;
					end
					used = 1'b1;
				end else begin
					// The byte closes every remaining argument as zero.
					for (int k = 1; k < 4; k++) begin
						if (3'(k) < al) begin
							res[n] = '0;
							n = n + 1'b1;
							res[n] = '0;
							n = n + 1'b1;
						end
					end
					al = '0;
					m  = M_TOP;
				end
			end
		end

		if (!used) begin
			case (m)
				M_IDLE: begin
				end
				M_TOP: begin
					if (ch == CH_NUL || ch == CH_HASH) begin
						res[n] = '{code: 8'd0, err: 1'b0, done: 1'b1};
						n = n + 1'b1;
						m = M_IDLE;
					end else if (ch == CH_LT) begin
						m  = M_NAME;
						nm = '0;
						nc = '0;
					end else begin
						res[n] = '{code: STR_MARK, err: 1'b0, done: 1'b0};
						n = n + 1'b1;
						if (ch != CH_NL) begin
							res[n] = '{code: ch, err: 1'b0, done: 1'b0};
							n = n + 1'b1;
						end
						m = M_TEXT;
					end
				end
				M_TEXT: begin
					if (ch == CH_NUL || ch == CH_HASH) begin
						res[n] = '0;
						n = n + 1'b1;
						res[n] = '{code: 8'd0, err: 1'b0, done: 1'b1};
						n = n + 1'b1;
						m = M_IDLE;
					end else if (ch == CH_LT) begin
						res[n] = '0;
						n = n + 1'b1;
						m  = M_NAME;
						nm = '0;
						nc = '0;
					end else if (ch != CH_NL) begin
						res[n] = '{code: ch, err: 1'b0, done: 1'b0};
						n = n + 1'b1;
					end
				end
				M_NAME: begin
					nm = {name_q[7:0], ch};
					if (ncnt_q < 2'd2) begin
						nc = ncnt_q + 2'd1;
					end else begin
						nc = '0;
						if (!lk.hit) begin
							res[n] = '{code: 8'd0, err: 1'b1, done: 1'b1};
							n = n + 1'b1;
							m = M_IDLE;
						end else if (lk.idx == '0) begin
							res[n] = '{code: 8'd0, err: 1'b0, done: 1'b1};
							n = n + 1'b1;
							m = M_IDLE;
						end else begin
							res[n] = '{code: {1'b0, lk.idx}, err: 1'b0, done: 1'b0};
							n = n + 1'b1;
							al = OP_ARGS[lk.idx];
							dc = '0;
							v  = '0;
							m  = (al != 3'd0) ? M_ARG : M_TOP;
						end
					end
				end
				default: begin
					m = M_IDLE;
				end
			endcase
		end

		// A tenth result does not fit and waits for the next byte (dropped on new_event).
		if (n > CNT_W'(MAX_RESULTS)) begin
			pv = 1'b1;
			pb = res[MAX_RESULTS].code;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			batch.r[i] = res[i];
		end
		batch.cnt = (n > CNT_W'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			name_q <= '0;
			ncnt_q <= '0;
			args_q <= '0;
			dc_q   <= '0;
			val_q  <= '0;
			pv_q   <= 1'b0;
			pb_q   <= '0;
		end else if (load) begin
			mode_q <= m;
			name_q <= nm;
			ncnt_q <= nc;
			args_q <= al;
			dc_q   <= dc;
			val_q  <= v;
			pv_q   <= pv;
			pb_q   <= pb;
		end
	end

endmodule

`default_nettype wire

/* sv/stb_outbuf.sv */
// ---------------------------------------------------------------------------
// Script text to bytecode: result buffer
// Registers one byte's batch of results and hands them out one by one.
// ---------------------------------------------------------------------------
`default_nettype none

module stb_outbuf (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load,
	input  wire stb_pkg::batch_t batch,
	output logic                free,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          code_byte,
	output logic                error,
	output logic                event_done,
	output logic                last_of_run
);
	import stb_pkg::*;

	res_t             buf_q [MAX_RESULTS];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rd_q;
	res_t             cur;

	assign out_valid   = (rd_q < cnt_q);
	assign cur         = buf_q[rd_q];
	assign code_byte   = cur.code;
	assign error       = cur.err;
	assign event_done  = cur.done;
	assign last_of_run = (rd_q + 1'b1 == cnt_q);
	// The buffer takes a new batch when it is empty or as its last request leaves.
	assign free        = !out_valid || (out_ready && last_of_run);

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MAX_RESULTS; i++) begin
				buf_q[i] <= batch.r[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (load) begin
			cnt_q <= batch.cnt;
			rd_q  <= '0;
		end else if (out_valid && out_ready) begin
			rd_q <= rd_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

/* sv/stb_checker.sv */
// ---------------------------------------------------------------------------
// Script text to bytecode: port checker
// Watches the top level's ports over time.
// ---------------------------------------------------------------------------
`default_nettype none

module stb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] code_byte,
	input wire logic       error,
	input wire logic       event_done,
	input wire logic       last_of_run
);

	// A stalled request keeps its code byte and last_of_run flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_byte)
			&& $stable(last_of_run))
		else $error("output request changed while stalled");

	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> event_done && code_byte == 8'd0)
		else $error("error result malformed");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_done |-> last_of_run)
		else $error("event end not last of its run");

	// A byte may only enter while no result is pending or as the previous batch finishes leaving.
	a_in_gate: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_valid |-> out_ready && last_of_run)
		else $error("input accepted over pending results");

endmodule

bind script_text_to_bytecode stb_checker u_stb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.code_byte   (code_byte),
	.error       (error),
	.event_done  (event_done),
	.last_of_run (last_of_run)
);

`default_nettype wire
